// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file, sic_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, quiet while reset is asserted (active-low reset).
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

// ===== hdl/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Types, constants and the half-step coil table for the index calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

    localparam int SIC_COUNT_BITS   = 16;
    localparam int SIC_PERIOD_BITS  = 16;
    localparam int SIC_SHOWN_BITS   = 16;
    localparam logic [SIC_PERIOD_BITS-1:0] SIC_PERIOD_RESET = 16'd5;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SEEK  = 2'd1,
        MODE_COUNT = 2'd2
    } t_mode;

    typedef struct packed {
        logic action;
        logic opto_level;
    } t_in_word;

    typedef struct packed {
        logic [3:0]                coils;
        logic                      is_calibrated;
        logic [SIC_SHOWN_BITS-1:0] steps_per_rev;
        logic                      busy_res;
    } t_out_word;

    // half-step pattern, bit3 = first coil
    function automatic logic [3:0] sic_coils(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1100;
            3'd2:    pat = 4'b0100;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0010;
            3'd5:    pat = 4'b0011;
            3'd6:    pat = 4'b0001;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sic_step.sv =====
// ----------------------------------------------------------------------------
// sic_step
// Calibration state machine: edge detect, step divider, step tally and the
// result word for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_step #(
    parameter int COUNT_BITS = sic_pkg::SIC_COUNT_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [sic_pkg::SIC_PERIOD_BITS-1:0]   i_cfg_wdata,
    input  wire                                   i_fire,
    input  sic_pkg::t_in_word                     i_word,
    output sic_pkg::t_out_word                    o_result
);
    import sic_pkg::*;

    t_mode                      r_mode, n_mode;
    logic [2:0]                 r_phase, n_phase;
    logic                       r_prev, n_prev;
    logic [SIC_PERIOD_BITS-1:0] r_div, n_div;
    logic [COUNT_BITS-1:0]      r_tally, n_tally;
    logic [COUNT_BITS-1:0]      r_stored, n_stored;
    logic                       r_valid, n_valid;
    logic [SIC_PERIOD_BITS-1:0] r_step_period;

    logic [SIC_PERIOD_BITS-1:0] period_eff;
    logic [SIC_PERIOD_BITS:0]   div_inc;
    logic                       step_hit;
    logic                       falling;
    logic [31:0]                stored_ext;

    // divider step; a zero period behaves as one
    assign period_eff = (r_step_period == '0) ? SIC_PERIOD_BITS'(1) : r_step_period;
    assign div_inc    = {1'b0, r_div} + (SIC_PERIOD_BITS+1)'(1);
    assign step_hit   = (div_inc >= {1'b0, period_eff});
    assign falling    = r_prev & ~i_word.opto_level;

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_div    = r_div;
        n_tally  = r_tally;
        n_stored = r_stored;
        n_valid  = r_valid;
        if (i_fire) begin
            n_prev = i_word.opto_level;
            if (i_word.action) begin
                n_valid = 1'b0;
                n_mode  = MODE_SEEK;
                n_div   = '0;
                n_tally = '0;
            end else begin
                unique case (r_mode)
                    MODE_SEEK: begin
                        if (falling) begin
                            n_mode  = MODE_COUNT;
                            n_div   = '0;
                            n_tally = '0;
                        end else if (step_hit) begin
                            n_div   = '0;
                            n_phase = r_phase - 3'd1;
                        end else begin
                            n_div   = div_inc[SIC_PERIOD_BITS-1:0];
                        end
                    end
                    MODE_COUNT: begin
                        if (falling) begin
                            n_stored = r_tally;
                            n_valid  = 1'b1;
                            n_mode   = MODE_IDLE;
                        end else if (step_hit) begin
                            n_div   = '0;
                            n_phase = r_phase - 3'd1;
                            if (!(&r_tally)) begin
                                n_tally = r_tally + COUNT_BITS'(1);
                            end
                        end else begin
                            n_div   = div_inc[SIC_PERIOD_BITS-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result word reflects the state after this tick
    assign stored_ext = 32'(n_stored);

    always_comb begin
        o_result.coils         = sic_coils(n_phase);
        o_result.is_calibrated = n_valid;
        o_result.busy_res      = (n_mode == MODE_SEEK) || (n_mode == MODE_COUNT);
        if (!n_valid) begin
            o_result.steps_per_rev = '0;
        end else if (|stored_ext[31:SIC_SHOWN_BITS]) begin
            o_result.steps_per_rev = '1;
        end else begin
            o_result.steps_per_rev = stored_ext[SIC_SHOWN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_phase       <= '0;
            r_prev        <= 1'b1;
            r_div         <= '0;
            r_tally       <= '0;
            r_stored      <= '0;
            r_valid       <= 1'b0;
            r_step_period <= SIC_PERIOD_RESET;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_div    <= n_div;
            r_tally  <= n_tally;
            r_stored <= n_stored;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_step_period <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sic_out_buf.sv =====
// ----------------------------------------------------------------------------
// sic_out_buf
// Output register with a skid stage so the core keeps moving while a word
// waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_out_buf (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  sic_pkg::t_out_word i_word,
    output logic               o_space,
    output logic               o_valid,
    input  wire                i_ready,
    output sic_pkg::t_out_word o_word
);
    import sic_pkg::*;

    t_out_word r_main, r_skid;
    logic      r_main_valid, r_skid_valid;
    logic      pop;

    assign pop     = r_main_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            r_skid <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stepper_index_calibrator_core.sv =====
// ----------------------------------------------------------------------------
// stepper_index_calibrator_core
// Half-step stepper drive that measures half-steps per index revolution.
//
//   channel  dir  handshake                 word
//   in       in   i_in_valid / o_in_ready   t_in_word  (action, opto_level)
//   out      out  o_out_valid / i_out_ready t_out_word (coils, flags, count)
//   cfg      in   i_cfg_we                  step_period, 16 bits
//
// One tick word per cycle while the output is not stalled; the word passes the
// input register, then the state update into the output register.
// Reset is synchronous; it clears mode, phase, counters, flags and sets
// step_period to 5. A stalled output fills the skid stage, after which
// o_in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_index_calibrator_core #(
    parameter int COUNT_BITS = sic_pkg::SIC_COUNT_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  sic_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output sic_pkg::t_out_word                  o_out_word,
    input  wire                                 i_cfg_we,
    input  wire  [sic_pkg::SIC_PERIOD_BITS-1:0] i_cfg_wdata
);
    import sic_pkg::*;

    t_in_word  r_in_word;
    logic      r_in_valid;
    logic      buf_space;
    logic      advance;
    t_out_word result;

    assign advance    = r_in_valid & buf_space;
    assign o_in_ready = ~r_in_valid | buf_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    sic_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (advance),
        .i_word      (r_in_word),
        .o_result    (result)
    );

    sic_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_word  (result),
        .o_space (buf_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== hdl/sic_checker.sv =====
// ----------------------------------------------------------------------------
// sic_checker
// Port-level checks for the index calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sic_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_out_valid,
    input wire                                 i_out_ready,
    input sic_pkg::t_out_word                  o_out_word
);
    import sic_pkg::*;

    // stalled output word holds
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))

    // a finished measurement means the drive is idle
    `ASSERT_CLK_RST(a_cal_not_busy, i_clk, i_rst_n, o_out_valid |-> !(o_out_word.is_calibrated && o_out_word.busy_res))

    // no count shown until calibrated
    `ASSERT_CLK_RST(a_count_zero, i_clk, i_rst_n, (o_out_valid && !o_out_word.is_calibrated) |-> (o_out_word.steps_per_rev == '0))

    // reset empties the output
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind stepper_index_calibrator_core sic_checker u_sic_checker (.*);

`default_nettype wire
